// File: sv/fifo_with_xon_xoff_flow_control_assert.svh
// assertion macros for the xon/xoff fifo checker
`ifndef FIFO_WITH_XON_XOFF_FLOW_CONTROL_ASSERT_SVH
`define FIFO_WITH_XON_XOFF_FLOW_CONTROL_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FXF_ASSERT_NOW(label, cond, body) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (body)) \
        else $error("fxf check failed");

// next-cycle implication, sampled on clk, off during reset
`define FXF_ASSERT_NEXT(label, cond, body) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (body)) \
        else $error("fxf check failed");

`endif

// File: sv/fxf_pkg.sv
// shared types and constants for the xon/xoff byte fifo
`default_nettype none

package fxf_pkg;

    localparam int DEPTH = 8;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > 4) ? CNT_W : 4;

    localparam int DATA_W  = 8;
    localparam int LEVEL_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_XOFF_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XON_LEVEL  = 2'd1;

    localparam logic [LEVEL_W-1:0] XOFF_LEVEL_RST = 4'd8;
    localparam logic [LEVEL_W-1:0] XON_LEVEL_RST  = 4'd4;

    typedef struct packed {
        logic [LEVEL_W-1:0] xoff_level;
        logic [LEVEL_W-1:0] xon_level;
    } cfg_t;

    typedef struct packed {
        logic              data_valid;
        logic [DATA_W-1:0] data_out;
        logic              xoff_pulse;
        logic              xon_pulse;
        logic              dropped;
        logic [3:0]        fill_level;
    } result_t;

endpackage

`default_nettype wire

// File: sv/fxf_core.sv
// ring buffer state and the per-word push/pop update with xon/xoff hysteresis
`default_nettype none

module fxf_core
    import fxf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              command,
    input  wire logic [DATA_W-1:0] data_in,
    input  wire cfg_t              cfg,
    output result_t                res
);

    logic [DATA_W-1:0] store_reg [DEPTH];

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             paused_reg, paused_next;
    logic             resumed_reg, resumed_next;

    logic             full;
    logic             empty;
    logic             wr_en;
    logic [EXT_W-1:0] cnt_ext;
    logic [EXT_W-1:0] xoff_ext;
    logic [EXT_W-1:0] xon_ext;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign xoff_ext = EXT_W'(cfg.xoff_level);
    assign xon_ext  = EXT_W'(cfg.xon_level);

    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        cnt_next     = cnt_reg;
        cnt_ext      = EXT_W'(cnt_reg);
        paused_next  = paused_reg;
        resumed_next = resumed_reg;
        wr_en        = 1'b0;
        res          = '0;

        case (command)
            CMD_PUSH:
            begin
                if (full)
                begin
                    res.dropped = 1'b1;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                cnt_ext = EXT_W'(cnt_next);
                // xoff check runs even when the word was dropped
                if (cnt_ext >= xoff_ext && !paused_reg)
                begin
                    paused_next    = 1'b1;
                    resumed_next   = 1'b0;
                    res.xoff_pulse = 1'b1;
                end
            end
            CMD_POP:
            begin
                if (!empty)
                begin
                    res.data_valid = 1'b1;
                    res.data_out   = store_reg[rd_ptr_reg];
                    rd_ptr_next    = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                    cnt_next       = cnt_reg - 1'b1;
                    cnt_ext        = EXT_W'(cnt_next);
                    if (cnt_ext < xon_ext && !resumed_reg)
                    begin
                        resumed_next  = 1'b1;
                        paused_next   = 1'b0;
                        res.xon_pulse = 1'b1;
                    end
                end
            end
            default:
            begin
                res = '0;
            end
        endcase

        res.fill_level = cnt_ext[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            cnt_reg     <= '0;
            paused_reg  <= 1'b0;
            resumed_reg <= 1'b0;
        end
        else if (step)
        begin
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            cnt_reg     <= cnt_next;
            paused_reg  <= paused_next;
            resumed_reg <= resumed_next;
        end
    end

    // byte storage, no reset: only written entries are ever read
    always_ff @(posedge clk)
    begin
        if (step && wr_en)
        begin
            store_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

`default_nettype wire

// File: sv/fifo_with_xon_xoff_flow_control.sv
// top level of the byte fifo with xon/xoff flow control
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | command, data_in
//  out     | out_valid / out_ready| data_valid, data_out, xoff_pulse, xon_pulse,
//          |                      | dropped, fill_level
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word per cycle while in_ready is high: the update runs in the cycle a word
// is taken and its result lands in the output register, visible on the next cycle
// in_ready stays high while the output register is empty or being drained
// reset clears pointers, count, xon/xoff flags and sets the levels to 8 and 4
// cfg_ready is always high; a write lands at the edge it is taken
`default_nettype none

module fifo_with_xon_xoff_flow_control
    import fxf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 command,
    input  wire logic [DATA_W-1:0]    data_in,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      data_valid,
    output logic [DATA_W-1:0]         data_out,
    output logic                      xoff_pulse,
    output logic                      xon_pulse,
    output logic                      dropped,
    output logic [3:0]                fill_level,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEVEL_W-1:0]   cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_XOFF_LEVEL: cfg_next.xoff_level = cfg_data;
                CFG_XON_LEVEL:  cfg_next.xon_level  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    fxf_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .command (command),
        .data_in (data_in),
        .cfg     (cfg_reg),
        .res     (res)
    );

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.xoff_level <= XOFF_LEVEL_RST;
            cfg_reg.xon_level  <= XON_LEVEL_RST;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_valid = res_reg.data_valid;
    assign data_out   = res_reg.data_out;
    assign xoff_pulse = res_reg.xoff_pulse;
    assign xon_pulse  = res_reg.xon_pulse;
    assign dropped    = res_reg.dropped;
    assign fill_level = res_reg.fill_level;

endmodule

`default_nettype wire

// File: sv/fxf_checker.sv
// port-level checks for the xon/xoff fifo, bound to the top level
`default_nettype none

`include "fifo_with_xon_xoff_flow_control_assert.svh"

module fxf_checker
    import fxf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              data_valid,
    input wire logic [DATA_W-1:0] data_out,
    input wire logic              xoff_pulse,
    input wire logic              xon_pulse,
    input wire logic              dropped,
    input wire logic [3:0]        fill_level
);

    logic        out_stall;
    logic [15:0] out_word;

    assign out_stall = out_valid && !out_ready;
    assign out_word  = {data_valid, data_out, xoff_pulse, xon_pulse, dropped, fill_level};

    // a stalled result word holds its payload
    `FXF_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word))

    // a pop result never carries push flags
    `FXF_ASSERT_NOW(a_pop_flags, out_valid && data_valid, !dropped && !xoff_pulse)

    // a drop only happens with the buffer full and no byte returned
    `FXF_ASSERT_NOW(a_drop_full, out_valid && dropped, fill_level == 4'(DEPTH) && !data_valid)

    // no byte returned means a zero data field and no xon
    `FXF_ASSERT_NOW(a_empty_zero, out_valid && !data_valid, data_out == '0 && !xon_pulse)

endmodule

bind fifo_with_xon_xoff_flow_control fxf_checker u_fxf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_valid (data_valid),
    .data_out   (data_out),
    .xoff_pulse (xoff_pulse),
    .xon_pulse  (xon_pulse),
    .dropped    (dropped),
    .fill_level (fill_level)
);

`default_nettype wire

// File: sim/tb_fifo_with_xon_xoff_flow_control.sv
// testbench for the xon/xoff byte fifo: random push/pop words checked against a predictor
`timescale 1ns / 1ps

module tb_fifo_with_xon_xoff_flow_control;
    import fxf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 180;

    typedef enum int unsigned { RX_OPEN, RX_THROTTLE, RX_COIN, RX_CHOKE } rx_mode_t;

    class rx_fifo_tracker;
        logic [DATA_W-1:0]  mem_bytes [DEPTH];
        int unsigned        rd_idx;
        int unsigned        wr_idx;
        int unsigned        held;
        bit                 paused;
        bit                 resumed;
        logic [LEVEL_W-1:0] xoff_lvl;
        logic [LEVEL_W-1:0] xon_lvl;
        result_t            expected_results [$];
        int unsigned        errors;

        function new();
            rd_idx   = 0;
            wr_idx   = 0;
            held     = 0;
            paused   = 0;
            resumed  = 0;
            xoff_lvl = XOFF_LEVEL_RST;
            xon_lvl  = XON_LEVEL_RST;
            errors   = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void write_level(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
            if (idx == CFG_XOFF_LEVEL)
                xoff_lvl = val;
            else if (idx == CFG_XON_LEVEL)
                xon_lvl = val;
        endfunction

        // works out the result of one accepted word and queues it
        function void take_word(logic cmd, logic [DATA_W-1:0] din);
            result_t r;
            r = '0;
            if (cmd == CMD_PUSH) begin
                if (held >= DEPTH) begin
                    r.dropped = 1'b1;
                end
                else begin
                    mem_bytes[wr_idx] = din;
                    wr_idx = (wr_idx + 1) % DEPTH;
                    held++;
                end
                // xoff check runs even when the push was dropped
                if (held >= xoff_lvl && !paused) begin
                    paused       = 1;
                    resumed      = 0;
                    r.xoff_pulse = 1'b1;
                end
            end
            else if (held != 0) begin
                r.data_valid = 1'b1;
                r.data_out   = mem_bytes[rd_idx];
                rd_idx = (rd_idx + 1) % DEPTH;
                held--;
                if (held < xon_lvl && !resumed) begin
                    resumed     = 1;
                    paused      = 0;
                    r.xon_pulse = 1'b1;
                end
            end
            r.fill_level = 4'(held);
            expected_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_word(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                report("result word with nothing pending");
                return;
            end
            want = expected_results.pop_front();
            compare_field("data_valid", 8'(got.data_valid), 8'(want.data_valid));
            compare_field("data_out", got.data_out, want.data_out);
            compare_field("xoff_pulse", 8'(got.xoff_pulse), 8'(want.xoff_pulse));
            compare_field("xon_pulse", 8'(got.xon_pulse), 8'(want.xon_pulse));
            compare_field("dropped", 8'(got.dropped), 8'(want.dropped));
            compare_field("fill_level", 8'(got.fill_level), 8'(want.fill_level));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 command;
    logic [DATA_W-1:0]    data_in;
    logic                 out_valid;
    logic                 out_ready;
    logic                 data_valid;
    logic [DATA_W-1:0]    data_out;
    logic                 xoff_pulse;
    logic                 xon_pulse;
    logic                 dropped;
    logic [3:0]           fill_level;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_data;

    rx_fifo_tracker tracker;

    fifo_with_xon_xoff_flow_control u_top (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // caller sits at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(logic cmd, logic [DATA_W-1:0] din);
        in_valid <= 1'b1;
        command  <= cmd;
        data_in  <= din;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.take_word(cmd, din);
        @(negedge clk);
    endtask

    // stop sending and wait for every outstanding result word
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.write_level(idx, val);
        @(negedge clk);
    endtask

    task automatic set_levels(logic [LEVEL_W-1:0] xoff, logic [LEVEL_W-1:0] xon, bit poke_unused);
        write_reg(CFG_XOFF_LEVEL, xoff);
        write_reg(CFG_XON_LEVEL, xon);
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, 4'($urandom_range(0, 15)));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        logic [DATA_W-1:0] fill_bytes [8];
        fill_bytes = '{8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7E, 8'h0F, 8'hF0};
        // pop from empty, then the first pop after reset gives xon with no xoff before it
        send_word(CMD_POP, 8'hFF);
        send_word(CMD_PUSH, 8'h00);
        send_word(CMD_POP, 8'h00);
        // fill up to xoff, then push into a full buffer
        for (int i = 0; i < 8; i++)
            send_word(CMD_PUSH, fill_bytes[i]);
        send_word(CMD_PUSH, 8'hC3);
        for (int i = 0; i < 8; i++)
            send_word(CMD_POP, 8'($urandom_range(0, 255)));
        send_word(CMD_POP, 8'h5A);
    endtask

    // bursts with a random push bias so the fill swings between empty and full
    task automatic run_random(int unsigned count, bit hold_midway);
        int unsigned sent;
        int unsigned burst;
        int unsigned push_pct;
        int unsigned gap;
        logic        cmd;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       push_pct = 15;
                1:       push_pct = 50;
                2:       push_pct = 85;
                default: push_pct = 60;
            endcase
            for (int i = 0; i < burst && sent < count; i++) begin
                cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
                send_word(cmd, 8'($urandom_range(0, 255)));
                sent++;
                if (hold_midway && sent == count / 2)
                    drain();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // receiver back-pressure, switching pattern every so often
    initial begin
        rx_mode_t    mode;
        int unsigned left;
        int unsigned cyc;
        out_ready = 1'b0;
        cyc = 0;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            left = $urandom_range(20, 200);
            repeat (left) begin
                @(negedge clk);
                cyc++;
                case (mode)
                    RX_OPEN:     out_ready <= 1'b1;
                    RX_THROTTLE: out_ready <= (cyc % 4) != 3;
                    RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
                    default:     out_ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin : result_monitor
        result_t got;
        if (rst_n && out_valid && out_ready) begin
            got = {data_valid, data_out, xoff_pulse, xon_pulse, dropped, fill_level};
            tracker.check_word(got);
        end
    end

    initial begin
        logic [LEVEL_W-1:0] xoff_plan [PHASES];
        logic [LEVEL_W-1:0] xon_plan [PHASES];
        xoff_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd3, 4'd15, 4'd2};
        xon_plan  = '{4'd1, 4'd8, 4'd0, 4'd0,  4'd2, 4'd7, 4'd15, 4'd8};
        tracker   = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = CMD_PUSH;
        data_in   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_levels(xoff_plan[p], xon_plan[p], p == 0);
            @(negedge clk);
            run_random(WORDS_PER_PHASE, p == 4);
        end
        drain();
        repeat (4) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
